### hdl/deop_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// deop_pkg
// Shared types and constants for the EDNS OPT parse and pad unit.
// ---------------------------------------------------------------------------
package deop_pkg;

    localparam int unsigned MaxMsg = 65535;

    localparam logic [15:0] TypeOpt        = 16'd41;
    localparam logic [15:0] CodePad        = 16'd12;
    localparam logic [7:0]  PtrBits        = 8'hC0;
    localparam logic [15:0] MinUdp         = 16'd512;
    localparam logic [16:0] LenLimit       = 17'd65535;
    localparam logic [7:0]  DoMask         = 8'h80;
    localparam logic [4:0]  OptOverhead    = 5'd4;
    localparam logic [4:0]  NewOptOverhead = 5'd15;

    localparam logic [1:0] CfgBlockSize  = 2'd0;
    localparam logic [1:0] CfgCreateOpt  = 2'd1;
    localparam logic [1:0] CfgBufferSize = 2'd2;
    localparam logic [1:0] CfgProbeCode  = 2'd3;

    localparam logic [1:0] StMalformed = 2'd0;
    localparam logic [1:0] StNoOpt     = 2'd1;
    localparam logic [1:0] StOpt       = 2'd2;

    localparam logic [1:0] ActNone   = 2'd0;
    localparam logic [1:0] ActPadOpt = 2'd1;
    localparam logic [1:0] ActNewOpt = 2'd2;

    typedef enum logic [3:0] {
        t_ph_hdr, t_ph_qname, t_ph_qptr, t_ph_qfix, t_ph_rname,
        t_ph_rptr, t_ph_rfix, t_ph_rdata, t_ph_done
    } t_phase;

    // controller states
    typedef enum logic [1:0] {
        S_PARSE, S_DIV, S_EMIT
    } t_ctl_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] message_length;
        logic [15:0] rdlen_offset;
        logic [15:0] rdlen_value;
        logic        opt_is_last;
        logic        do_flag;
        logic        has_probe_option;
        logic        has_padding;
        logic [15:0] udp_size;
        logic [1:0]  pad_action;
        logic [15:0] new_length;
        logic [15:0] pad_count;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_word;

    // controller -> datapath
    typedef struct packed {
        logic parse;     // consume one byte
        logic div_start; // latch rounding operands
        logic div_step;  // one quotient bit
        logic finish;    // build result and clear parse state
        logic out_take;  // result word handed off
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage
`default_nettype wire

### hdl/deop_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// deop_if
// Valid/ready channel carrying one payload word.
// ---------------------------------------------------------------------------
interface deop_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/deop_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// deop_ctrl
// Sequencer: parse bytes, run the rounding divider, present the result.
// ---------------------------------------------------------------------------
module deop_ctrl import deop_pkg::*; (
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_in_valid,
    input  wire  logic i_in_last,
    input  wire  logic i_out_ready,
    input  wire  t_sts i_sts,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);
    t_ctl_state r_state, n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_PARSE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_PARSE: if (i_in_valid && i_in_last) n_state = S_DIV;
            S_DIV:   if (i_sts.div_done) n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_ready)
                    n_state = (i_in_valid && i_in_last) ? S_DIV : S_PARSE;
            end
            default: n_state = S_PARSE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_PARSE: begin
                o_in_ready    = 1'b1;
                o_cmd.parse   = i_in_valid;
                o_cmd.div_start = i_in_valid && i_in_last;
            end
            S_DIV: begin
                o_cmd.div_step = !i_sts.div_done;
                o_cmd.finish   = i_sts.div_done;
            end
            S_EMIT: begin
                // keep parsing the next message; hold its last byte until
                // the result word leaves
                o_out_valid     = 1'b1;
                o_cmd.out_take  = i_out_ready;
                o_in_ready      = !i_in_last || i_out_ready;
                o_cmd.parse     = i_in_valid && (!i_in_last || i_out_ready);
                o_cmd.div_start = i_in_valid && i_in_last && i_out_ready;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### hdl/deop_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// deop_dp
// Parse state, OPT tracking, block rounding divider and result register.
// ---------------------------------------------------------------------------
module deop_dp import deop_pkg::*; (
    input  wire  logic       i_clk,
    input  wire  logic       i_rst_n,
    input  wire  t_cmd       i_cmd,
    input  wire  t_in_word   i_in,
    input  wire  logic       i_cfg_we,
    input  wire  t_cfg_word  i_cfg,
    output t_sts             o_sts,
    output t_out_word        o_out
);
    // configuration
    logic [15:0] r_block_size, r_buffer_size, r_probe_code;
    logic        r_new_opt_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= 16'd128;
            r_new_opt_en  <= 1'b1;
            r_buffer_size <= 16'd65535;
            r_probe_code  <= 16'd12;
        end else if (i_cfg_we) begin
            unique case (i_cfg.index)
                CfgBlockSize:  r_block_size  <= i_cfg.data;
                CfgCreateOpt:  r_new_opt_en  <= i_cfg.data[0];
                CfgBufferSize: r_buffer_size <= i_cfg.data;
                CfgProbeCode:  r_probe_code  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // parse state
    logic [16:0] r_pos, n_pos;
    t_phase      r_ph, n_ph;
    logic [15:0] r_qc, n_qc;
    logic [17:0] r_rc, n_rc;
    logic [7:0]  r_lab, n_lab;
    logic [3:0]  r_fi, n_fi;
    logic [15:0] r_rtype, n_rtype, r_rclass, n_rclass, r_rrem, n_rrem;
    logic [1:0]  r_wh, n_wh;
    logic [15:0] r_wcode, n_wcode, r_wlen, n_wlen, r_wskip, n_wskip;
    logic [15:0] r_foff, n_foff, r_flen, n_flen;
    logic [17:0] r_fend, n_fend;
    logic        r_found, n_found, r_cur, n_cur, r_probe, n_probe;
    logic        r_pad, n_pad, r_do, n_do, r_err, n_err;
    logic [15:0] r_udp, n_udp;

    logic [7:0]  b;
    logic [15:0] v16;
    logic        fin_rec;

    always_comb begin
        n_pos = r_pos; n_ph = r_ph; n_qc = r_qc; n_rc = r_rc; n_lab = r_lab;
        n_fi = r_fi; n_rtype = r_rtype; n_rclass = r_rclass; n_rrem = r_rrem;
        n_wh = r_wh; n_wcode = r_wcode; n_wlen = r_wlen; n_wskip = r_wskip;
        n_foff = r_foff; n_flen = r_flen; n_fend = r_fend;
        n_found = r_found; n_cur = r_cur; n_probe = r_probe; n_pad = r_pad;
        n_do = r_do; n_err = r_err; n_udp = r_udp;
        b = i_in.data_byte;
        v16 = '0;
        fin_rec = 1'b0;
        if (r_pos <= 17'(MaxMsg)) n_pos = r_pos + 17'd1;
        if (n_pos > 17'(MaxMsg)) n_err = 1'b1;
        if (!n_err) begin
            unique case (r_ph)
                t_ph_hdr: begin
                    if (r_pos == 17'd4) n_qc = {b, 8'd0};
                    else if (r_pos == 17'd5) n_qc = r_qc | {8'd0, b};
                    else if (r_pos == 17'd6 || r_pos == 17'd8 || r_pos == 17'd10)
                        n_rtype = {8'd0, b};
                    else if (r_pos == 17'd7 || r_pos == 17'd9 || r_pos == 17'd11)
                        n_rc = r_rc + {2'd0, r_rtype[7:0], b};
                    if (r_pos == 17'd11) begin
                        n_rtype = '0;
                        n_lab = '0;
                        if (r_qc != 0) n_ph = t_ph_qname;
                        else n_ph = (n_rc != 0) ? t_ph_rname : t_ph_done;
                    end
                end
                t_ph_qname, t_ph_rname: begin
                    if (r_lab != 0) n_lab = r_lab - 8'd1;
                    else if (b == 0) begin
                        n_ph = (r_ph == t_ph_qname) ? t_ph_qfix : t_ph_rfix;
                        n_fi = '0;
                    end else if ((b & PtrBits) == PtrBits)
                        n_ph = (r_ph == t_ph_qname) ? t_ph_qptr : t_ph_rptr;
                    else if ((b & PtrBits) != 0) n_err = 1'b1;
                    else n_lab = b;
                end
                t_ph_qptr: begin n_ph = t_ph_qfix; n_fi = '0; end
                t_ph_rptr: begin n_ph = t_ph_rfix; n_fi = '0; end
                t_ph_qfix: begin
                    n_fi = r_fi + 4'd1;
                    if (n_fi == 4'd4) begin
                        n_qc = r_qc - 16'd1;
                        n_lab = '0;
                        if (n_qc != 0) n_ph = t_ph_qname;
                        else n_ph = (r_rc != 0) ? t_ph_rname : t_ph_done;
                    end
                end
                t_ph_rfix: begin
                    n_fi = r_fi + 4'd1;
                    unique case (r_fi)
                        4'd0: n_rtype = {b, 8'd0};
                        4'd1: n_rtype = r_rtype | {8'd0, b};
                        4'd2: n_rclass = {b, 8'd0};
                        4'd3: n_rclass = r_rclass | {8'd0, b};
                        4'd6: if (r_rtype == TypeOpt && !r_found)
                                  n_do = (b & DoMask) != 0;
                        4'd8: n_rrem = {b, 8'd0};
                        4'd9: begin
                            v16 = r_rrem | {8'd0, b};
                            n_rrem = v16;
                            n_fi = r_fi;
                            if (r_rtype == TypeOpt && r_found) n_err = 1'b1;
                            else begin
                                if (r_rtype == TypeOpt) begin
                                    n_found = 1'b1; n_cur = 1'b1;
                                    n_foff = 16'(r_pos - 17'd1);
                                    n_flen = v16;
                                    n_fend = {1'b0, r_pos} + 18'd1 + {2'd0, v16};
                                    n_wh = '0; n_wcode = '0; n_wlen = '0;
                                    n_wskip = '0;
                                end else n_cur = 1'b0;
                                if (v16 == 0) fin_rec = 1'b1;
                                else n_ph = t_ph_rdata;
                            end
                        end
                        default: ;
                    endcase
                end
                t_ph_rdata: begin
                    n_rrem = r_rrem - 16'd1;
                    if (r_cur) begin
                        if (r_wskip != 0) n_wskip = r_wskip - 16'd1;
                        else begin
                            unique case (r_wh)
                                2'd0: begin n_wcode = {b, 8'd0}; n_wh = 2'd1; end
                                2'd1: begin
                                    v16 = r_wcode | {8'd0, b};
                                    n_wcode = v16;
                                    if (v16 == r_probe_code) n_probe = 1'b1;
                                    if (v16 == CodePad) n_pad = 1'b1;
                                    n_wh = 2'd2;
                                end
                                2'd2: begin n_wlen = {b, 8'd0}; n_wh = 2'd3; end
                                default: begin
                                    n_wskip = r_wlen | {8'd0, b};
                                    n_wh = 2'd0;
                                end
                            endcase
                        end
                    end
                    if (n_rrem == 0) fin_rec = 1'b1;
                end
                default: n_err = 1'b1;
            endcase
            // close the record
            if (fin_rec) begin
                if (n_cur) begin
                    n_udp = (r_rclass < MinUdp) ? MinUdp : r_rclass;
                    if (n_wh != 0 || n_wskip != 0) n_err = 1'b1;
                    n_cur = 1'b0;
                end
                if (!n_err) begin
                    n_rc = r_rc - 18'd1;
                    n_ph = (n_rc != 0) ? t_ph_rname : t_ph_done;
                    n_lab = '0;
                end
            end
        end
    end

    // end-of-message decision, computed from the updated state
    logic [1:0] r_status;
    logic [16:0] r_len;
    logic        r_go, r_fnd;
    logic [17:0] r_prov;
    logic [15:0] r_blk;
    logic [17:0] r_rem, r_quo;
    logic [4:0]  r_cnt;
    logic        r_islast;

    logic [1:0]  c_status;
    logic        c_go;
    logic [17:0] c_prov;
    logic [18:0] c_sub;

    always_comb begin
        if (n_err || n_ph != t_ph_done) c_status = StMalformed;
        else c_status = n_found ? StOpt : StNoOpt;
        if (c_status == StOpt) begin
            c_go   = !n_pad && (n_fend == {1'b0, n_pos});
            c_prov = {1'b0, n_pos} + {13'd0, OptOverhead};
        end else begin
            c_go   = r_new_opt_en;
            c_prov = {1'b0, n_pos} + {13'd0, NewOptOverhead};
        end
        c_sub = {r_rem, r_quo[17]} - {3'd0, r_blk};
    end

    // rounding: ceil(prov/blk) by restoring division, one bit a cycle
    logic [33:0] nl_full;
    assign nl_full = {16'd0, r_quo + 18'd1} * {18'd0, r_blk};
    logic [33:0] nl_use;
    assign nl_use = (r_prov == 0) ? 34'd0 : nl_full;
    logic ok;
    assign ok = r_go && r_status != StMalformed && nl_use <= {18'd0, r_buffer_size}
                && nl_use <= {17'd0, LenLimit};
    logic [15:0] mlen;
    assign mlen = (r_len > LenLimit) ? 16'hFFFF : r_len[15:0];

    assign o_sts.div_done = (r_cnt == 5'd18);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_pos <= '0; r_ph <= t_ph_hdr; r_qc <= '0; r_rc <= '0; r_lab <= '0;
            r_fi <= '0; r_rtype <= '0; r_rclass <= '0; r_rrem <= '0;
            r_wh <= '0; r_wcode <= '0; r_wlen <= '0; r_wskip <= '0;
            r_foff <= '0; r_flen <= '0; r_fend <= '0;
            r_found <= 1'b0; r_cur <= 1'b0; r_probe <= 1'b0; r_pad <= 1'b0;
            r_do <= 1'b0; r_err <= 1'b0; r_udp <= MinUdp;
        end else if (i_cmd.parse) begin
            r_pos <= n_pos; r_ph <= n_ph; r_qc <= n_qc; r_rc <= n_rc;
            r_lab <= n_lab; r_fi <= n_fi; r_rtype <= n_rtype;
            r_rclass <= n_rclass; r_rrem <= n_rrem; r_wh <= n_wh;
            r_wcode <= n_wcode; r_wlen <= n_wlen; r_wskip <= n_wskip;
            r_foff <= n_foff; r_flen <= n_flen; r_fend <= n_fend;
            r_found <= n_found; r_cur <= n_cur; r_probe <= n_probe;
            r_pad <= n_pad; r_do <= n_do; r_err <= n_err; r_udp <= n_udp;
        end
    end

    // latch division operands, then shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_status <= c_status;
            r_len    <= n_pos;
            r_go     <= c_go;
            r_fnd    <= (c_status == StOpt);
            r_prov   <= c_prov;
            r_blk    <= (r_block_size == 0) ? 16'd1 : r_block_size;
            r_islast <= (c_status == StOpt) && (n_fend == {1'b0, n_pos});
            r_rem    <= '0;
            r_quo    <= c_prov - 18'd1;
            r_cnt    <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 5'd1;
            if (!c_sub[18]) begin
                r_rem <= c_sub[17:0];
                r_quo <= {r_quo[16:0], 1'b1};
            end else begin
                r_rem <= {r_rem[16:0], r_quo[17]};
                r_quo <= {r_quo[16:0], 1'b0};
            end
        end
    end

    // hold the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out.status           <= r_status;
            o_out.message_length   <= mlen;
            o_out.rdlen_offset     <= r_fnd ? r_foff : 16'd0;
            o_out.rdlen_value      <= r_fnd ? r_flen : 16'd0;
            o_out.opt_is_last      <= r_islast;
            o_out.do_flag          <= r_fnd && r_do;
            o_out.has_probe_option <= r_fnd && r_probe;
            o_out.has_padding      <= r_fnd && r_pad;
            o_out.udp_size         <= r_udp;
            o_out.pad_action       <= ok ? (r_fnd ? ActPadOpt : ActNewOpt) : ActNone;
            o_out.new_length       <= ok ? nl_use[15:0] : mlen;
            o_out.pad_count        <= ok ? 16'(nl_use[17:0] - r_prov) : 16'd0;
        end
    end

    logic unused;
    assign unused = i_cmd.out_take ^ i_in.last_byte ^ (^r_wcode[7:0]);
endmodule
`default_nettype wire

### hdl/dns_edns_opt_parse_pad_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dns_edns_opt_parse_pad_unit
// Streaming DNS parser that locates the OPT record and plans padding.
// ---------------------------------------------------------------------------
// Input channel: one message byte per word with a last-byte mark.
// Each byte is parsed in the cycle it is accepted (one byte per cycle while ready).
// Output channel: one result word per message, after its last byte.
// After the last byte the block runs the block rounding (a bit-serial
// 18-bit divider) and then holds the result until taken.
// While the result waits, bytes of the next message are still parsed;
// only that message's last byte is held until the result word leaves,
// so a stalled receiver stalls the input there. No byte is accepted
// while the rounding runs.
// Configuration: write channel of register index and data, always ready;
// write only while idle. Reset loads block size 128, new-OPT enable 1,
// buffer size 65535, probe code 12 and clears the parse state.
// ---------------------------------------------------------------------------
module dns_edns_opt_parse_pad_unit import deop_pkg::*; (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    deop_if.sink       in_ch,
    deop_if.source     out_ch,
    deop_if.sink       cfg_ch
);
    t_cmd cmd;
    t_sts sts;

    assign cfg_ch.ready = 1'b1;

    deop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_last   (in_ch.data.last_byte),
        .i_out_ready (out_ch.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_cmd       (cmd)
    );

    deop_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in     (in_ch.data),
        .i_cfg_we (cfg_ch.valid),
        .i_cfg    (cfg_ch.data),
        .o_sts    (sts),
        .o_out    (out_ch.data)
    );
endmodule
`default_nettype wire

### tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// EDNS OPT parse and pad unit testbench
// Streams DNS messages byte by byte through the unit and checks each result
// word against an in-bench parser that tracks the header counts, names,
// record fields and the OPT option list and then plans the padding. A short
// table of directed messages runs first, then random messages (mostly
// well-formed, some corrupted) under several register settings.
// ---------------------------------------------------------------------------
module testbench;
    import deop_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    deop_if #(.T(t_in_word))  in_ch();
    deop_if #(.T(t_out_word)) out_ch();
    deop_if #(.T(t_cfg_word)) cfg_ch();

    dns_edns_opt_parse_pad_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // register copies
    int unsigned blk_reg, create_reg, bufsz_reg, probe_reg;

    // parse state copy
    int unsigned byte_cnt;
    t_phase      phase;
    int unsigned qd_left, rr_left, label_left, fix_idx;
    int unsigned rr_type, rr_class, rd_left;
    int unsigned opt_hdr_idx, opt_code, opt_len_hi, opt_skip;
    int unsigned rdlen_ofs, rdlen_val, opt_end;
    bit          seen_opt, in_opt, seen_probe, seen_pad, do_bit;
    int unsigned udp_latch;
    bit          bad;

    t_out_word   result_q[$];
    int          errors;

    // sender and receiver pacing
    bit          gaps_on;
    int          burst_left;
    int          rx_mode;
    int          rx_cnt = 0;
    int          phase_bytes;

    logic [7:0]  msg_q[$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] status;
    } t_row;

    localparam int NRows = 40;
    localparam t_row DirTable [NRows] = '{
        // lone byte: short header
        '{8'hFF, 1'b1, 1'b1, StMalformed},
        // bare header, no sections
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b1, 1'b1, StNoOpt},
        // one OPT record carrying a padding option
        '{8'hAB, 1'b0, 1'b0, 2'd0}, '{8'hCD, 1'b0, 1'b0, 2'd0},
        '{8'h01, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h01, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h29, 1'b0, 1'b0, 2'd0},
        '{8'h10, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h80, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h04, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h0C, 1'b0, 1'b0, 2'd0},
        '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b1, 1'b1, StOpt}
    };

    function automatic void clear_parse();
        byte_cnt = 0;
        phase = t_ph_hdr;
        qd_left = 0; rr_left = 0; label_left = 0; fix_idx = 0;
        rr_type = 0; rr_class = 0; rd_left = 0;
        opt_hdr_idx = 0; opt_code = 0; opt_len_hi = 0; opt_skip = 0;
        rdlen_ofs = 0; rdlen_val = 0; opt_end = 0;
        seen_opt = 0; in_opt = 0; seen_probe = 0; seen_pad = 0; do_bit = 0;
        udp_latch = 512;
        bad = 0;
    endfunction

    function automatic void enter_records();
        phase = (rr_left != 0) ? t_ph_rname : t_ph_done;
        label_left = 0;
    endfunction

    function automatic void enter_questions();
        if (qd_left != 0) begin
            phase = t_ph_qname;
            label_left = 0;
        end else begin
            enter_records();
        end
    endfunction

    function automatic void end_name(bit q);
        phase = q ? t_ph_qfix : t_ph_rfix;
        fix_idx = 0;
    endfunction

    function automatic void name_octet(logic [7:0] b, bit q);
        if (label_left != 0) begin
            label_left--;
        end else if (b == 8'h00) begin
            end_name(q);
        end else if ((b & PtrBits) == PtrBits) begin
            phase = q ? t_ph_qptr : t_ph_rptr;
        end else if ((b & PtrBits) != 0) begin
            bad = 1;
        end else begin
            label_left = b;
        end
    endfunction

    function automatic void close_record();
        if (in_opt) begin
            udp_latch = (rr_class < 512) ? 512 : rr_class;
            if (opt_hdr_idx != 0 || opt_skip != 0) bad = 1;
            in_opt = 0;
        end
        if (!bad) begin
            rr_left--;
            enter_records();
        end
    endfunction

    function automatic void option_octet(logic [7:0] b);
        if (opt_skip != 0) begin
            opt_skip--;
        end else begin
            case (opt_hdr_idx)
                0: begin
                    opt_code = {b, 8'h00};
                    opt_hdr_idx = 1;
                end
                1: begin
                    opt_code = opt_code | b;
                    if (opt_code == probe_reg) seen_probe = 1;
                    if (opt_code == CodePad) seen_pad = 1;
                    opt_hdr_idx = 2;
                end
                2: begin
                    opt_len_hi = {b, 8'h00};
                    opt_hdr_idx = 3;
                end
                default: begin
                    opt_skip = opt_len_hi | b;
                    opt_hdr_idx = 0;
                end
            endcase
        end
    endfunction

    function automatic void fixed_octet(logic [7:0] b, int unsigned pos);
        case (fix_idx)
            0: rr_type = {b, 8'h00};
            1: rr_type = rr_type | b;
            2: rr_class = {b, 8'h00};
            3: rr_class = rr_class | b;
            6: if (rr_type == TypeOpt && !seen_opt) do_bit = (b & DoMask) != 0;
            8: rd_left = {b, 8'h00};
            9: begin
                rd_left = rd_left | b;
                if (rr_type == TypeOpt) begin
                    if (seen_opt) begin
                        bad = 1;
                        return;
                    end
                    seen_opt = 1;
                    in_opt = 1;
                    rdlen_ofs = (pos - 1) & 16'hFFFF;
                    rdlen_val = rd_left;
                    opt_end = pos + 1 + rd_left;
                    opt_hdr_idx = 0; opt_code = 0; opt_len_hi = 0; opt_skip = 0;
                end else begin
                    in_opt = 0;
                end
                if (rd_left == 0) close_record();
                else phase = t_ph_rdata;
                return;
            end
            default: ;
        endcase
        fix_idx++;
    endfunction

    function automatic void parse_octet(logic [7:0] b, int unsigned pos);
        case (phase)
            t_ph_hdr: begin
                if (pos == 4) qd_left = {b, 8'h00};
                else if (pos == 5) qd_left = qd_left | b;
                else if (pos == 6 || pos == 8 || pos == 10) rr_type = b;
                else if (pos == 7 || pos == 9 || pos == 11)
                    rr_left = rr_left + ((rr_type << 8) | b);
                if (pos == 11) begin
                    rr_type = 0;
                    enter_questions();
                end
            end
            t_ph_qname: name_octet(b, 1);
            t_ph_rname: name_octet(b, 0);
            t_ph_qptr:  end_name(1);
            t_ph_rptr:  end_name(0);
            t_ph_qfix: begin
                fix_idx++;
                if (fix_idx == 4) begin
                    qd_left--;
                    enter_questions();
                end
            end
            t_ph_rfix: fixed_octet(b, pos);
            t_ph_rdata: begin
                rd_left--;
                if (in_opt) option_octet(b);
                if (rd_left == 0) close_record();
            end
            default: bad = 1;
        endcase
    endfunction

    // build the result word for the message just ended
    function automatic t_out_word plan_padding();
        t_out_word   w;
        int unsigned len, mlen, blk, over, prov, nl;
        bit          found, go;
        len = byte_cnt;
        mlen = (len > 65535) ? 65535 : len;
        w = '0;
        if (bad || phase != t_ph_done) w.status = StMalformed;
        else w.status = seen_opt ? StOpt : StNoOpt;
        found = (w.status == StOpt);
        w.pad_action = ActNone;
        w.new_length = 16'(mlen);
        if (w.status != StMalformed) begin
            if (found) begin
                go = !seen_pad && opt_end == len;
                over = OptOverhead;
            end else begin
                go = create_reg != 0;
                over = NewOptOverhead;
            end
            if (go) begin
                blk = (blk_reg != 0) ? blk_reg : 1;
                prov = len + over;
                nl = ((prov + blk - 1) / blk) * blk;
                if (nl <= bufsz_reg && nl <= 65535) begin
                    w.pad_action = found ? ActPadOpt : ActNewOpt;
                    w.new_length = 16'(nl);
                    w.pad_count = 16'(nl - prov);
                end
            end
        end
        w.message_length = 16'(mlen);
        if (found) begin
            w.rdlen_offset = 16'(rdlen_ofs);
            w.rdlen_value = 16'(rdlen_val);
            w.opt_is_last = (opt_end == len);
            w.do_flag = do_bit;
            w.has_probe_option = seen_probe;
            w.has_padding = seen_pad;
        end
        w.udp_size = 16'(udp_latch);
        return w;
    endfunction

    function automatic void accept_octet(logic [7:0] b, bit last);
        int unsigned pos;
        pos = byte_cnt;
        if (byte_cnt <= MaxMsg) byte_cnt++;
        if (byte_cnt > MaxMsg) bad = 1;
        if (!bad) parse_octet(b, pos);
        if (last) begin
            result_q.push_back(plan_padding());
            clear_parse();
        end
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CfgBlockSize:  blk_reg = val;
            CfgCreateOpt:  create_reg = val[0];
            CfgBufferSize: bufsz_reg = val;
            default:       probe_reg = val;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_regs(int unsigned blk, int unsigned cr, int unsigned bs,
                            int unsigned pc);
        write_reg(CfgBlockSize, 16'(blk));
        write_reg(CfgCreateOpt, 16'(cr));
        write_reg(CfgBufferSize, 16'(bs));
        write_reg(CfgProbeCode, 16'(pc));
    endtask

    // drive one word, honoring the burst and gap pattern
    task automatic send_octet(logic [7:0] b, bit last);
        @(negedge i_clk);
        if (gaps_on && burst_left <= 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        phase_bytes++;
        accept_octet(b, last);
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg_q.size(); i++)
            send_octet(msg_q[i], i == msg_q.size() - 1);
    endtask

    // drop valid and let the last result drain
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        wait (result_q.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic void add_name();
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            int ll;
            if ($urandom_range(0, 99) < 3) begin
                // reserved label type
                msg_q.push_back($urandom_range(0, 1) ? (8'h40 | 8'($urandom_range(0, 63)))
                                                      : (8'h80 | 8'($urandom_range(0, 63))));
                return;
            end
            ll = $urandom_range(1, 6);
            msg_q.push_back(8'(ll));
            repeat (ll) msg_q.push_back(8'($urandom));
        end
        if ($urandom_range(0, 99) < 70) begin
            msg_q.push_back(8'h00);
        end else begin
            msg_q.push_back(8'hC0 | 8'($urandom_range(0, 63)));
            msg_q.push_back(8'($urandom));
        end
    endfunction

    function automatic void add_record(bit is_opt);
        logic [7:0]  rd[$];
        logic [15:0] cls;
        int          sel;
        if (is_opt && $urandom_range(0, 99) < 80) msg_q.push_back(8'h00);
        else add_name();
        if (is_opt) begin
            msg_q.push_back(8'h00);
            msg_q.push_back(TypeOpt[7:0]);
            sel = $urandom_range(0, 5);
            cls = (sel == 0) ? 16'd0 : (sel == 1) ? 16'd511 : (sel == 2) ? 16'd512 :
                  (sel == 3) ? 16'd4096 : (sel == 4) ? 16'hFFFF : 16'($urandom);
        end else begin
            msg_q.push_back(8'($urandom));
            msg_q.push_back(8'($urandom));
            cls = 16'($urandom);
        end
        msg_q.push_back(cls[15:8]);
        msg_q.push_back(cls[7:0]);
        repeat (4) msg_q.push_back(8'($urandom));
        if (is_opt) begin
            repeat ($urandom_range(0, 3)) begin
                logic [15:0] code;
                int          ol;
                sel = $urandom_range(0, 2);
                code = (sel == 0) ? CodePad : (sel == 1) ? 16'(probe_reg) : 16'($urandom);
                ol = $urandom_range(0, 4);
                rd.push_back(code[15:8]);
                rd.push_back(code[7:0]);
                rd.push_back(8'h00);
                rd.push_back(8'(ol));
                repeat (ol) rd.push_back(8'($urandom));
            end
            // option list that does not tile
            if ($urandom_range(0, 99) < 12)
                repeat ($urandom_range(1, 3)) rd.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 6)) rd.push_back(8'($urandom));
        end
        msg_q.push_back(8'h00);
        msg_q.push_back(8'(rd.size()));
        foreach (rd[i]) msg_q.push_back(rd[i]);
    endfunction

    function automatic void build_msg();
        int qd, an, ar, opt_at, opt2_at, mode, n;
        msg_q.delete();
        mode = $urandom_range(0, 99);
        if (mode < 5) begin
            repeat ($urandom_range(1, 40)) msg_q.push_back(8'($urandom));
            return;
        end
        qd = $urandom_range(0, 2);
        an = $urandom_range(0, 2);
        ar = $urandom_range(0, 2);
        opt_at = -1;
        opt2_at = -1;
        if (ar > 0 && $urandom_range(0, 99) < 75)
            opt_at = ($urandom_range(0, 99) < 80) ? ar - 1 : 0;
        if (ar > 1 && $urandom_range(0, 99) < 10) begin
            opt_at = 0;
            opt2_at = 1;
        end
        repeat (4) msg_q.push_back(8'($urandom));
        msg_q.push_back(8'h00); msg_q.push_back(8'(qd));
        msg_q.push_back(8'h00); msg_q.push_back(8'(an));
        msg_q.push_back(8'h00); msg_q.push_back(8'h00);
        msg_q.push_back(8'h00); msg_q.push_back(8'(ar));
        repeat (qd) begin
            add_name();
            repeat (4) msg_q.push_back(8'($urandom));
        end
        repeat (an) add_record(0);
        for (int i = 0; i < ar; i++) add_record(i == opt_at || i == opt2_at);
        n = msg_q.size();
        // corrupt a share of the well-formed messages
        if (mode < 13) msg_q[$urandom_range(0, n - 1)] = 8'($urandom);
        else if (mode < 19) msg_q = msg_q[0:$urandom_range(0, n - 1)];
        else if (mode < 24) repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom));
    endfunction

    task automatic run_random(int nbytes);
        phase_bytes = 0;
        while (phase_bytes < nbytes) begin
            build_msg();
            send_msg();
        end
    endtask

    // stall pattern of the receiver
    always @(negedge i_clk) begin
        rx_cnt <= rx_cnt + 1;
        case (rx_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= (rx_cnt % 16) >= 10;
        endcase
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", out_ch.data);
            end else begin
                t_out_word want;
                want = result_q.pop_front();
                if (out_ch.data !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch exp st=%0d len=%0d ofs=%0d rdl=%0d last=%0d do=%0d",
                                 want.status, want.message_length, want.rdlen_offset,
                                 want.rdlen_value, want.opt_is_last, want.do_flag);
                        $display("  exp probe=%0d pad=%0d udp=%0d act=%0d nl=%0d cnt=%0d",
                                 want.has_probe_option, want.has_padding, want.udp_size,
                                 want.pad_action, want.new_length, want.pad_count);
                        $display("  got st=%0d len=%0d ofs=%0d rdl=%0d last=%0d do=%0d",
                                 out_ch.data.status, out_ch.data.message_length,
                                 out_ch.data.rdlen_offset, out_ch.data.rdlen_value,
                                 out_ch.data.opt_is_last, out_ch.data.do_flag);
                        $display("  got probe=%0d pad=%0d udp=%0d act=%0d nl=%0d cnt=%0d",
                                 out_ch.data.has_probe_option, out_ch.data.has_padding,
                                 out_ch.data.udp_size, out_ch.data.pad_action,
                                 out_ch.data.new_length, out_ch.data.pad_count);
                    end
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rx_mode = 0;
        gaps_on = 0;
        burst_left = 0;
        errors = 0;
        blk_reg = 128; create_reg = 1; bufsz_reg = 65535; probe_reg = 12;
        clear_parse();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, reset register values
        for (int r = 0; r < NRows; r++) begin
            send_octet(DirTable[r].data, DirTable[r].last);
            if (DirTable[r].typed && result_q[$].status != DirTable[r].status) begin
                errors++;
                if (errors <= 10)
                    $display("row %0d: status %0d, table says %0d",
                             r, result_q[$].status, DirTable[r].status);
            end
        end
        run_random(200);

        wait_idle();
        rx_mode = 1; gaps_on = 1;
        set_regs(1, 0, 65535, 0);
        run_random(200);

        wait_idle();
        rx_mode = 2;
        set_regs(65535, 1, 12, 65535);
        run_random(200);

        wait_idle();
        rx_mode = 1;
        set_regs(468, 1, 65535, $urandom);
        run_random(200);

        wait_idle();
        rx_mode = 2; gaps_on = 0;
        set_regs($urandom_range(1, 600), $urandom_range(0, 1), $urandom_range(12, 2000), 12);
        run_random(200);

        wait_idle();
        rx_mode = 1; gaps_on = 1;
        set_regs(128, 1, 65535, $urandom_range(0, 15));
        run_random(200);

        wait_idle();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
